// File: rtl/core/assert_macros.svh
// Assertion macros shared by the DFA matcher modules.
// Depends on nothing; files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `ASSERT_IMPL(lbl, clk, rstn, !(cond), msg)

`endif

// File: rtl/core/tdfa_pkg.sv
// Types and constants of the table-driven DFA matcher.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package tdfa_pkg;

  localparam int unsigned StateW   = 5;
  localparam int unsigned SymW     = 8;
  localparam int unsigned ColInW   = 4;
  localparam int unsigned CountW   = 5;
  localparam int unsigned PosW     = 16;

  localparam logic [SymW-1:0]   WildcardByte = 8'h3F;
  localparam logic [PosW-1:0]   PosMax       = 16'hFFFF;
  localparam logic [StateW-1:0] StateInit    = 5'd1;

  typedef enum logic [1:0] {
    KIND_CHAR   = 2'd0,
    KIND_ALPHA  = 2'd1,
    KIND_TRANS  = 2'd2,
    KIND_ACCEPT = 2'd3
  } kind_e;

  // VERDICT_ACCEPT also serves as the "no failure yet" code of the matcher.
  typedef enum logic [1:0] {
    VERDICT_ACCEPT   = 2'd0,
    VERDICT_REJECT   = 2'd1,
    VERDICT_NO_TRANS = 2'd2,
    VERDICT_UNKNOWN  = 2'd3
  } verdict_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_STEP = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic start;
    logic finish;
    logic wr_alpha;
    logic wr_trans;
    logic wr_accept;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic out_busy;
  } status_t;

endpackage

// File: rtl/core/table_driven_dfa_matcher.sv
// Character item: the table read is issued at accept (ST_IDLE) and the next state is taken from the
// registered RAM data in ST_STEP; the state-to-table-read loop through that RAM sets the rate.
// Load items are written as they are accepted and keep the controller in ST_IDLE. A verdict is in
// the result register the cycle after the last character's ST_STEP; a full result register stalls only that step.
// Reset (async, active low): state 1, accept flags and counters cleared, symbol_count 1;
// alphabet and transition table are not cleared.
`timescale 1ns / 1ps

module table_driven_dfa_matcher
  import tdfa_pkg::*;
#(
  parameter int unsigned STATE_COUNT   = 16,
  parameter int unsigned ALPHABET_SIZE = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        kind_i,
  input  logic [SymW-1:0]   symbol_i,
  input  logic              last_i,
  input  logic [StateW-1:0] state_index_i,
  input  logic [ColInW-1:0] column_i,
  input  logic [StateW-1:0] next_state_i,
  input  logic              accept_flag_i,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        verdict_o,
  output logic [StateW-1:0] final_state_o,
  output logic [PosW-1:0]   error_position_o
);

  cmd_t    cmd;
  status_t status;

  tdfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_e'(kind_i)),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tdfa_dp #(
    .STATE_COUNT   (STATE_COUNT),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .symbol_i         (symbol_i),
    .last_i           (last_i),
    .state_index_i    (state_index_i),
    .column_i         (column_i),
    .next_state_i     (next_state_i),
    .accept_flag_i    (accept_flag_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .verdict_o        (verdict_o),
    .final_state_o    (final_state_o),
    .error_position_o (error_position_o)
  );

endmodule

// File: rtl/core/tdfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module tdfa_ram #(
  parameter int unsigned Width = 5,
  parameter int unsigned Depth = 256,
  localparam int unsigned Aw   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/tdfa_ctrl.sv
// Controller state machine of the DFA matcher: accepts items, issues commands.
// Depends on tdfa_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tdfa_ctrl
  import tdfa_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  kind_e   kind_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (kind_i)
            KIND_CHAR: begin
              cmd_o.start = 1'b1;
              state_d     = ST_STEP;
            end
            KIND_ALPHA:  cmd_o.wr_alpha  = 1'b1;
            KIND_TRANS:  cmd_o.wr_trans  = 1'b1;
            KIND_ACCEPT: cmd_o.wr_accept = 1'b1;
          endcase
        end
      end
      ST_STEP: begin
        // A verdict waits here until the result register is free.
        if (!(status_i.last && status_i.out_busy)) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
    endcase
  end

  `ASSERT_IMPL(a_char_blocks_input, clk_i, rst_ni, (in_valid_i && in_ready_o && kind_i == KIND_CHAR) |=> !in_ready_o, "input taken during a character step")

endmodule

// File: rtl/core/tdfa_dp.sv
// Datapath of the DFA matcher: alphabet, accept flags, table RAM, match state, result.
// Depends on tdfa_pkg, tdfa_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tdfa_dp
  import tdfa_pkg::*;
#(
  parameter int unsigned STATE_COUNT   = 16,
  parameter int unsigned ALPHABET_SIZE = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output status_t           status_o,
  input  logic [SymW-1:0]   symbol_i,
  input  logic              last_i,
  input  logic [StateW-1:0] state_index_i,
  input  logic [ColInW-1:0] column_i,
  input  logic [StateW-1:0] next_state_i,
  input  logic              accept_flag_i,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        verdict_o,
  output logic [StateW-1:0] final_state_o,
  output logic [PosW-1:0]   error_position_o
);

  localparam int unsigned ColW     = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int unsigned NW       = $clog2(ALPHABET_SIZE + 1);
  localparam int unsigned AccW     = $clog2(STATE_COUNT);
  localparam int unsigned TblDepth = STATE_COUNT * ALPHABET_SIZE;
  localparam int unsigned TblAw    = $clog2(TblDepth);

  logic [SymW-1:0]   alpha_q [ALPHABET_SIZE];
  logic [STATE_COUNT-1:0] acc_q;
  logic [CountW-1:0] cnt_q;
  logic [StateW-1:0] state_q, state_d;
  verdict_e          fail_q, fail_d;
  logic [PosW-1:0]   pos_q, pos_d, fpos_q, fpos_d, pos_inc;
  logic              found_q, found_d, last_q, last_d;
  logic              out_valid_q, out_valid_d;
  logic [1:0]        verdict_q;
  logic [StateW-1:0] final_q;
  logic [PosW-1:0]   errpos_q;

  logic [NW-1:0]     n_use;
  logic              any_hit;
  logic [ColW-1:0]   hit_col;
  logic [7:0]        col_wide, sidx_wide, step_wide;
  logic              col_ok, sidx_ok;
  logic              tbl_we, tbl_re;
  logic [TblAw-1:0]  tbl_waddr, tbl_raddr;
  logic [StateW-1:0] tbl_rdata;
  logic              tgt_ok, acc_hit, emit;
  logic [StateW-1:0] step_state;
  verdict_e          step_fail, step_verdict;
  logic [PosW-1:0]   step_fpos;

  assign n_use = (int'(cnt_q) > ALPHABET_SIZE) ? NW'(ALPHABET_SIZE) : NW'(cnt_q);

  // The first column in use that matches wins; the last column in use may hold the wildcard.
  always_comb begin
    any_hit = 1'b0;
    hit_col = '0;
    for (int c = int'(ALPHABET_SIZE) - 1; c >= 0; c--) begin
      if (c < int'(n_use) &&
          (alpha_q[c] == symbol_i ||
           (c == int'(n_use) - 1 && alpha_q[c] == WildcardByte))) begin
        any_hit = 1'b1;
        hit_col = ColW'(c);
      end
    end
  end

  assign col_wide  = {4'd0, column_i};
  assign sidx_wide = {3'd0, state_index_i - StateW'(1)};
  assign col_ok    = int'(column_i) < ALPHABET_SIZE;
  assign sidx_ok   = state_index_i != '0 && int'(state_index_i) <= STATE_COUNT;

  assign tbl_we    = cmd_i.wr_trans && col_ok && sidx_ok;
  assign tbl_waddr = TblAw'(32'(state_index_i - StateW'(1)) * ALPHABET_SIZE
                            + 32'(column_i));
  assign tbl_re    = cmd_i.start && fail_q == VERDICT_ACCEPT && any_hit;
  assign tbl_raddr = TblAw'(32'(state_q - StateW'(1)) * ALPHABET_SIZE + 32'(hit_col));

  tdfa_ram #(
    .Width (StateW),
    .Depth (TblDepth)
  ) u_tbl (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (next_state_i),
    .re_i    (tbl_re),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  assign pos_inc = (pos_q == PosMax) ? pos_q : pos_q + PosW'(1);

  assign tgt_ok     = found_q && tbl_rdata != '0 && int'(tbl_rdata) <= STATE_COUNT;
  assign step_state = tgt_ok ? tbl_rdata : state_q;
  assign step_fail  = (found_q && !tgt_ok) ? VERDICT_NO_TRANS : fail_q;
  assign step_fpos  = (found_q && !tgt_ok) ? pos_q : fpos_q;
  assign step_wide  = {3'd0, step_state - StateW'(1)};
  assign acc_hit    = acc_q[step_wide[AccW-1:0]];
  assign step_verdict = (step_fail != VERDICT_ACCEPT) ? step_fail :
                        (acc_hit ? VERDICT_ACCEPT : VERDICT_REJECT);
  assign emit       = cmd_i.finish && last_q;

  always_comb begin
    state_d = state_q;
    fail_d  = fail_q;
    pos_d   = pos_q;
    fpos_d  = fpos_q;
    found_d = found_q;
    last_d  = last_q;
    if (cmd_i.start) begin
      last_d  = last_i;
      found_d = 1'b0;
      if (fail_q == VERDICT_ACCEPT) begin
        pos_d = pos_inc;
        if (any_hit) begin
          found_d = 1'b1;
        end else begin
          fail_d = VERDICT_UNKNOWN;
          fpos_d = pos_inc;
        end
      end
    end else if (cmd_i.finish) begin
      found_d = 1'b0;
      if (last_q) begin
        state_d = StateInit;
        fail_d  = VERDICT_ACCEPT;
        pos_d   = '0;
        fpos_d  = '0;
      end else begin
        state_d = step_state;
        fail_d  = step_fail;
        fpos_d  = step_fpos;
      end
    end
  end

  assign out_valid_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateInit;
      fail_q      <= VERDICT_ACCEPT;
      pos_q       <= '0;
      fpos_q      <= '0;
      found_q     <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= CountW'(1);
      acc_q       <= '0;
    end else begin
      state_q     <= state_d;
      fail_q      <= fail_d;
      pos_q       <= pos_d;
      fpos_q      <= fpos_d;
      found_q     <= found_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cnt_q <= cfg_wdata_i;
      end
      if (cmd_i.wr_accept && sidx_ok) begin
        acc_q[sidx_wide[AccW-1:0]] <= accept_flag_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_alpha && col_ok) begin
      alpha_q[col_wide[ColW-1:0]] <= symbol_i;
    end
    if (emit) begin
      verdict_q <= step_verdict;
      final_q   <= step_state;
      errpos_q  <= (step_fail != VERDICT_ACCEPT) ? step_fpos : '0;
    end
  end

  assign status_o.last     = last_q;
  assign status_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign verdict_o        = verdict_q;
  assign final_state_o    = final_q;
  assign error_position_o = errpos_q;

  `ASSERT_IMPL(a_state_in_range, clk_i, rst_ni, state_q != '0 && int'(state_q) <= STATE_COUNT, "match state out of range")
  `ASSERT_IMPL(a_fail_pos_paired, clk_i, rst_ni, (fail_q == VERDICT_ACCEPT) == (fpos_q == '0), "failure code and failure position disagree")
  `ASSERT_NEVER(a_tbl_one_access, clk_i, rst_ni, tbl_we && tbl_re, "table read and write in one cycle")

endmodule
